### src/sdsc_pkg.sv
// Shared types, codes and job builders for the SD card SPI-mode sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package sdsc_pkg;

  // Event op codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_DONE  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_JOB    = 2'd0;
  localparam logic [1:0] KIND_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Block results
  localparam logic [1:0] BLK_OK        = 2'd0;
  localparam logic [1:0] BLK_CRC_ERR   = 2'd1;
  localparam logic [1:0] BLK_NOT_READY = 2'd2;

  // Status event codes
  localparam logic [1:0] EVT_INIT      = 2'd0;
  localparam logic [1:0] EVT_ERROR     = 2'd1;
  localparam logic [1:0] EVT_BAD_CARD  = 2'd2;

  // Card kinds
  localparam logic [1:0] CARD_UNKNOWN = 2'd0;
  localparam logic [1:0] CARD_V1      = 2'd1;
  localparam logic [1:0] CARD_V2_SC   = 2'd2;
  localparam logic [1:0] CARD_V2_HC   = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] REG_INIT_RETRY = 8'd0;
  localparam logic [7:0] REG_TOKEN_POLL = 8'd1;

  // Sequencer states
  localparam logic [4:0] ST_UNDEF     = 5'd0;
  localparam logic [4:0] ST_RESET     = 5'd1;
  localparam logic [4:0] ST_RESET2    = 5'd2;
  localparam logic [4:0] ST_CMD8      = 5'd3;
  localparam logic [4:0] ST_A41_SEND  = 5'd4;
  localparam logic [4:0] ST_A41_ANS   = 5'd5;
  localparam logic [4:0] ST_A41_WAIT  = 5'd6;
  localparam logic [4:0] ST_OCR       = 5'd7;
  localparam logic [4:0] ST_READY     = 5'd8;
  localparam logic [4:0] ST_RD_CMD    = 5'd9;
  localparam logic [4:0] ST_RD_TOKEN  = 5'd10;
  localparam logic [4:0] ST_RD_PAUSE  = 5'd11;
  localparam logic [4:0] ST_RD_DATA   = 5'd12;
  localparam logic [4:0] ST_WR_CMD    = 5'd13;
  localparam logic [4:0] ST_WR_DATA   = 5'd14;
  localparam logic [4:0] ST_WR_BUSY   = 5'd15;
  localparam logic [4:0] ST_WR_STATUS = 5'd16;
  localparam logic [4:0] ST_ERROR     = 5'd17;

  // SD command indexes
  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_IF  = 6'd8;
  localparam logic [5:0] CMD_STATUS   = 6'd13;
  localparam logic [5:0] CMD_READ     = 6'd17;
  localparam logic [5:0] CMD_WRITE    = 6'd24;
  localparam logic [5:0] CMD_SEND_OP  = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [7:0]  CRC_NONE    = 8'hFF;
  localparam logic [7:0]  CMD_START   = 8'h40;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  DRESP_MASK  = 8'h1F;
  localparam logic [7:0]  DRESP_OK    = 8'h05;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [7:0]  OCR_CCS     = 8'h40;
  localparam logic [9:0]  LEN_CMD     = 10'd6;
  localparam logic [9:0]  LEN_DATA    = 10'd515;
  localparam logic [9:0]  LEN_R1      = 10'd3;
  localparam logic [9:0]  LEN_R7      = 10'd7;
  localparam logic [9:0]  LEN_R2      = 10'd4;
  localparam logic [9:0]  LEN_POLL    = 10'd1;
  localparam logic [9:0]  LEN_NONE    = 10'd0;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] request_block;
    logic        job_ok;
    logic [7:0]  response_byte0;
    logic [7:0]  response_byte1;
    logic [7:0]  response_byte2;
    logic        data_crc_ok;
  } evt_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command_byte;
    logic [31:0] command_arg;
    logic [7:0]  command_crc;
    logic [9:0]  tx_length;
    logic [9:0]  rx_length;
    logic        rx_to_data;
    logic [1:0]  block_result;
    logic [31:0] done_block;
    logic [1:0]  event_code;
    logic [4:0]  event_state;
    logic [1:0]  card_kind;
  } res_item_t;

  // Build a six-byte command job; CRC and response length follow the index.
  function automatic res_item_t cmd_item(input logic [5:0] idx, input logic [31:0] arg);
    res_item_t r;
    r = '0;
    r.kind         = KIND_JOB;
    r.command_byte = CMD_START | {2'b00, idx};
    r.command_arg  = arg;
    r.command_crc  = CRC_NONE;
    r.tx_length    = LEN_CMD;
    r.rx_length    = LEN_R1;
    case (idx)
      CMD_GO_IDLE:  r.command_crc = CRC_CMD0;
      CMD_SEND_IF: begin
        r.command_crc = CRC_CMD8;
        r.rx_length   = LEN_R7;
      end
      CMD_READ_OCR: r.rx_length = LEN_R7;
      CMD_STATUS:   r.rx_length = LEN_R2;
      default:      r.rx_length = LEN_R1;
    endcase
    return r;
  endfunction

  function automatic res_item_t data_item(input logic [9:0] tx, input logic [9:0] rx,
                                          input logic to_data);
    res_item_t r;
    r = '0;
    r.kind       = KIND_JOB;
    r.tx_length  = tx;
    r.rx_length  = rx;
    r.rx_to_data = to_data;
    return r;
  endfunction

  function automatic res_item_t done_item(input logic [1:0] result, input logic [31:0] blk);
    res_item_t r;
    r = '0;
    r.kind         = KIND_BLOCK;
    r.block_result = result;
    r.done_block   = blk;
    return r;
  endfunction

  function automatic res_item_t status_item(input logic [1:0] code, input logic [4:0] st,
                                            input logic [1:0] card);
    res_item_t r;
    r = '0;
    r.kind        = KIND_STATUS;
    r.event_code  = code;
    r.event_state = st;
    r.card_kind   = card;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/sdsc_channels.sv
// Handshake channels of the sequencer: event input, result output, register writes.
// Depends on sdsc_pkg for the payload types.
`default_nettype none

interface sdsc_evt_if import sdsc_pkg::*; ();
  logic      valid;
  logic      ready;
  evt_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdsc_res_if import sdsc_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdsc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

`default_nettype wire

### src/sd_spi_card_sequencer.sv
// SD card SPI-mode sequencer: init, card detection, single-block read and write.
// An accepted event beat is held in the event register until consumed; its result, if any,
// is then loaded into the result register. Throughput: one event beat per cycle while the
// result register is not stalled, set by the single state update between the two registers.
// Reset (rst, synchronous): state undefined, no job pending, card unknown,
// registers at 100 and 10 ticks, both pipeline registers empty.
`default_nettype none

module sd_spi_card_sequencer import sdsc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  sdsc_evt_if.sink    evt,
  sdsc_res_if.source  res,
  sdsc_cfg_if.sink    cfg
);

  // Configuration registers
  logic [15:0] init_retry_ticks;
  logic [15:0] token_poll_ticks;

  // Sequencer state
  logic [4:0]  ctrl_state, ctrl_state_next;
  logic [4:0]  after_job_state, after_job_state_next;
  logic        job_pending, job_pending_next;
  logic [15:0] wait_count, wait_count_next;
  logic [1:0]  detected_type, detected_type_next;
  logic [31:0] saved_block, saved_block_next;

  // Event register and result register
  logic        evt_valid_q;
  evt_item_t   evt_q;
  logic        res_valid_q;
  res_item_t   res_q;

  logic        advance;
  logic        emit;
  res_item_t   res_c;
  logic [31:0] blk_arg;

  // The event register moves on whenever the result register is free or drains
  // this cycle; an event with no result still needs that slot to be safe.
  assign advance   = evt_valid_q && (!res_valid_q || res.ready);
  assign evt.ready = !evt_valid_q || advance;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid_q;
  assign res.data  = res_q;

  // Standard-capacity v2 cards address in bytes
  assign blk_arg = (detected_type == CARD_V2_SC) ? {evt_q.request_block[22:0], 9'd0}
                                                 : evt_q.request_block;

  always_comb begin
    ctrl_state_next      = ctrl_state;
    after_job_state_next = after_job_state;
    job_pending_next     = job_pending;
    wait_count_next      = wait_count;
    detected_type_next   = detected_type;
    saved_block_next     = saved_block;
    emit                 = 1'b0;
    res_c                = '0;

    unique case (evt_q.op)
      OP_START: begin
        if (!job_pending) begin
          detected_type_next   = CARD_UNKNOWN;
          ctrl_state_next      = ST_UNDEF;
          res_c                = cmd_item(CMD_GO_IDLE, 32'd0);
          emit                 = 1'b1;
          job_pending_next     = 1'b1;
          after_job_state_next = ST_RESET;
        end
      end
      OP_READ, OP_WRITE: begin
        if (!job_pending) begin
          saved_block_next = evt_q.request_block;
          emit             = 1'b1;
          if (ctrl_state != ST_READY) begin
            res_c = done_item(BLK_NOT_READY, evt_q.request_block);
          end else if (evt_q.op == OP_WRITE) begin
            res_c                = cmd_item(CMD_WRITE, blk_arg);
            job_pending_next     = 1'b1;
            after_job_state_next = ST_WR_CMD;
          end else begin
            res_c                = cmd_item(CMD_READ, blk_arg);
            job_pending_next     = 1'b1;
            after_job_state_next = ST_RD_CMD;
          end
        end
      end
      OP_DONE: begin
        if (job_pending) begin
          job_pending_next = 1'b0;
          if (!evt_q.job_ok) begin
            ctrl_state_next = ST_ERROR;
          end else begin
            ctrl_state_next = after_job_state;
            // React to the finished job from the state it was issued for.
            // A failure reports that state and parks in error.
            unique case (after_job_state)
              ST_RESET, ST_RESET2: begin
                emit = 1'b1;
                if (evt_q.response_byte1 == R1_IDLE) begin
                  res_c                = cmd_item(CMD_SEND_IF, ARG_IF_COND);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_CMD8;
                end else if (after_job_state == ST_RESET) begin
                  // Retry CMD0 once
                  res_c                = cmd_item(CMD_GO_IDLE, 32'd0);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_RESET2;
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_CMD8: begin
                emit = 1'b1;
                if (evt_q.response_byte1 == R1_IDLE) begin
                  detected_type_next   = CARD_V2_SC;
                  res_c                = cmd_item(CMD_APP, 32'd0);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_A41_SEND;
                end else begin
                  // v1 cards are not served
                  detected_type_next = CARD_V1;
                  ctrl_state_next    = ST_ERROR;
                  res_c = status_item(EVT_BAD_CARD, after_job_state, CARD_V1);
                end
              end
              ST_A41_SEND: begin
                emit = 1'b1;
                if (evt_q.response_byte1 == R1_IDLE) begin
                  res_c = cmd_item(CMD_SEND_OP,
                                   (detected_type == CARD_V1) ? 32'd0 : ARG_HCS);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_A41_ANS;
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_A41_ANS: begin
                if (evt_q.response_byte1 == R1_IDLE) begin
                  // Still idle: wait, then poll again
                  wait_count_next = init_retry_ticks;
                  ctrl_state_next = ST_A41_WAIT;
                end else if (evt_q.response_byte1 == R1_READY) begin
                  emit                 = 1'b1;
                  res_c                = cmd_item(CMD_READ_OCR, 32'd0);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_OCR;
                end else begin
                  emit            = 1'b1;
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_OCR: begin
                emit = 1'b1;
                if (evt_q.response_byte1 == R1_READY) begin
                  if (detected_type == CARD_V2_SC &&
                      (evt_q.response_byte2 & OCR_CCS) != 8'd0) begin
                    detected_type_next = CARD_V2_HC;
                    res_c = status_item(EVT_INIT, ST_READY, CARD_V2_HC);
                  end else begin
                    res_c = status_item(EVT_INIT, ST_READY, detected_type);
                  end
                  ctrl_state_next = ST_READY;
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_RD_CMD: begin
                emit = 1'b1;
                // R1 may come one byte late
                if (evt_q.response_byte1 == R1_READY || evt_q.response_byte2 == R1_READY) begin
                  res_c                = data_item(LEN_NONE, LEN_POLL, 1'b0);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_RD_TOKEN;
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_RD_TOKEN: begin
                if (evt_q.response_byte0 == TOKEN_START) begin
                  emit                 = 1'b1;
                  res_c                = data_item(LEN_NONE, LEN_DATA, 1'b1);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_RD_DATA;
                end else begin
                  ctrl_state_next = ST_RD_PAUSE;
                  wait_count_next = token_poll_ticks;
                end
              end
              ST_RD_DATA: begin
                emit            = 1'b1;
                ctrl_state_next = ST_READY;
                res_c = done_item(evt_q.data_crc_ok ? BLK_OK : BLK_CRC_ERR, saved_block);
              end
              ST_WR_CMD: begin
                emit = 1'b1;
                if (evt_q.response_byte1 == R1_READY) begin
                  res_c                = data_item(LEN_DATA, LEN_R1, 1'b0);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_WR_DATA;
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_WR_DATA: begin
                emit = 1'b1;
                if ((evt_q.response_byte0 & DRESP_MASK) == DRESP_OK) begin
                  res_c                = data_item(LEN_NONE, LEN_POLL, 1'b0);
                  job_pending_next     = 1'b1;
                  after_job_state_next = ST_WR_BUSY;
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              ST_WR_BUSY: begin
                emit             = 1'b1;
                job_pending_next = 1'b1;
                // Card holds the line low while busy
                if (evt_q.response_byte0 == 8'd0) begin
                  res_c                = data_item(LEN_NONE, LEN_POLL, 1'b0);
                  after_job_state_next = ST_WR_BUSY;
                end else begin
                  res_c                = cmd_item(CMD_STATUS, 32'd0);
                  after_job_state_next = ST_WR_STATUS;
                end
              end
              ST_WR_STATUS: begin
                emit = 1'b1;
                if (evt_q.response_byte1 == R1_READY) begin
                  ctrl_state_next = ST_READY;
                  res_c           = done_item(BLK_OK, saved_block);
                end else begin
                  ctrl_state_next = ST_ERROR;
                  res_c = status_item(EVT_ERROR, after_job_state, detected_type);
                end
              end
              default: begin
                emit = 1'b0;
              end
            endcase
          end
        end
      end
      OP_TICK: begin
        // Count down only in a wait state; a zero count never expires
        if (!job_pending && (ctrl_state == ST_A41_WAIT || ctrl_state == ST_RD_PAUSE) &&
            wait_count != 16'd0) begin
          wait_count_next = wait_count - 16'd1;
          if (wait_count == 16'd1) begin
            emit             = 1'b1;
            job_pending_next = 1'b1;
            if (ctrl_state == ST_A41_WAIT) begin
              res_c                = cmd_item(CMD_APP, 32'd0);
              after_job_state_next = ST_A41_SEND;
            end else begin
              res_c                = data_item(LEN_NONE, LEN_POLL, 1'b0);
              after_job_state_next = ST_RD_TOKEN;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Event register: load on every accepted beat, drop once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid_q <= 1'b0;
    end else if (evt.ready) begin
      evt_valid_q <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      evt_q <= evt.data;
    end
  end

  // Result register: refill when free or draining, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res.ready) begin
      res_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_q <= res_c;
    end
  end

  // Sequencer state advances once per consumed event
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state      <= ST_UNDEF;
      after_job_state <= ST_UNDEF;
      job_pending     <= 1'b0;
      wait_count      <= 16'd0;
      detected_type   <= CARD_UNKNOWN;
      saved_block     <= 32'd0;
    end else if (advance) begin
      ctrl_state      <= ctrl_state_next;
      after_job_state <= after_job_state_next;
      job_pending     <= job_pending_next;
      wait_count      <= wait_count_next;
      detected_type   <= detected_type_next;
      saved_block     <= saved_block_next;
    end
  end

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      init_retry_ticks <= 16'd100;
      token_poll_ticks <= 16'd10;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_INIT_RETRY) begin
        init_retry_ticks <= cfg.value;
      end else if (cfg.index == REG_TOKEN_POLL) begin
        token_poll_ticks <= cfg.value;
      end
    end
  end

  // A held event must not be taken over while the result slot is blocked
  assert property (@(posedge clk) disable iff (rst)
    (evt_valid_q && res_valid_q && !res.ready) |-> !evt.ready)
    else $error("event beat accepted while result register stalled");

  // Every emitted SPI job leaves a job pending
  assert property (@(posedge clk) disable iff (rst)
    (advance && emit && res_c.kind == KIND_JOB) |=> job_pending)
    else $error("job request emitted without pending job");

  // State stays within the defined codes
  assert property (@(posedge clk) disable iff (rst)
    (ctrl_state <= ST_ERROR) && (after_job_state <= ST_ERROR))
    else $error("sequencer state out of range");

  // Nothing is offered right after reset
  assert property (@(posedge clk) $past(rst) |-> !res_valid_q)
    else $error("result valid right after reset");

  // A result beat only appears from a consumed event
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid_q) |-> $past(advance))
    else $error("result appeared without a consumed event");

endmodule

`default_nettype wire

### tb/tb_sd_spi_card_sequencer.sv
// Testbench for the SD card SPI-mode sequencer: directed bring-up and transfer tests,
// then card-like random traffic checked against a local behavioral predictor.
// Depends on sdsc_pkg, the sdsc channel interfaces and sd_spi_card_sequencer.
`timescale 1ns / 1ps

module tb_sd_spi_card_sequencer;
  import sdsc_pkg::*;

  // Op codes the block does not define; it must drop them.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // Register indexes past the end of the register file.
  localparam logic [7:0] REG_SPARE_LO = 8'd2;
  localparam logic [7:0] REG_SPARE_HI = 8'hFF;
  // The card holds its output low while it programs a block.
  localparam logic [7:0] BUSY_LOW = 8'h00;
  // No-beat cycles tolerated before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;

  sdsc_evt_if evt_ch ();
  sdsc_res_if res_ch ();
  sdsc_cfg_if cfg_ch ();

  sd_spi_card_sequencer dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the sequencer's registers and state.
  // ---------------------------------------------------------------------------
  logic [15:0] retry_reload;
  logic [15:0] poll_reload;
  logic [4:0]  seq_state;
  logic [4:0]  seq_return;
  bit          job_open;
  logic [15:0] tick_left;
  logic [1:0]  card_type;
  logic [31:0] last_block;

  res_item_t   due_outputs[$];

  // Run bookkeeping
  bit          steady;
  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned jobs_seen;
  int unsigned blocks_seen;
  int unsigned status_seen;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  // Queue a command job and remember where the answer leads.
  function automatic bit issue_command(output res_item_t r, input logic [5:0] idx,
                                       input logic [31:0] arg, input logic [4:0] nxt);
    r = '0;
    r.kind         = KIND_JOB;
    r.command_byte = CMD_START | {2'b00, idx};
    r.command_arg  = arg;
    r.command_crc  = CRC_NONE;
    r.tx_length    = LEN_CMD;
    r.rx_length    = LEN_R1;
    if (idx == CMD_GO_IDLE) begin
      r.command_crc = CRC_CMD0;
    end else if (idx == CMD_SEND_IF) begin
      r.command_crc = CRC_CMD8;
      r.rx_length   = LEN_R7;
    end else if (idx == CMD_READ_OCR) begin
      r.rx_length = LEN_R7;
    end else if (idx == CMD_STATUS) begin
      r.rx_length = LEN_R2;
    end
    job_open   = 1'b1;
    seq_return = nxt;
    return 1'b1;
  endfunction

  // Queue a data-only job (token poll, block read, block write, busy poll).
  function automatic bit issue_transfer(output res_item_t r, input logic [9:0] tx,
                                        input logic [9:0] rx, input logic to_data,
                                        input logic [4:0] nxt);
    r = '0;
    r.kind       = KIND_JOB;
    r.tx_length  = tx;
    r.rx_length  = rx;
    r.rx_to_data = to_data;
    job_open     = 1'b1;
    seq_return   = nxt;
    return 1'b1;
  endfunction

  function automatic bit report_block(output res_item_t r, input logic [1:0] result,
                                      input logic [31:0] blk);
    r = '0;
    r.kind         = KIND_BLOCK;
    r.block_result = result;
    r.done_block   = blk;
    return 1'b1;
  endfunction

  function automatic bit report_status(output res_item_t r, input logic [1:0] code,
                                       input logic [4:0] st);
    r = '0;
    r.kind        = KIND_STATUS;
    r.event_code  = code;
    r.event_state = st;
    r.card_kind   = card_type;
    return 1'b1;
  endfunction

  // Park in the error state and report the state that was left.
  function automatic bit abort_to_error(output res_item_t r, input logic [1:0] code);
    logic [4:0] prev;
    prev      = seq_state;
    seq_state = ST_ERROR;
    return report_status(r, code, prev);
  endfunction

  // React to the bytes of a finished job in the state the job was issued for.
  function automatic bit answer_job(input evt_item_t e, output res_item_t r);
    r = '0;
    case (seq_state)
      ST_RESET: begin
        if (e.response_byte1 == R1_IDLE)
          return issue_command(r, CMD_SEND_IF, ARG_IF_COND, ST_CMD8);
        return issue_command(r, CMD_GO_IDLE, '0, ST_RESET2);
      end
      ST_RESET2: begin
        if (e.response_byte1 == R1_IDLE)
          return issue_command(r, CMD_SEND_IF, ARG_IF_COND, ST_CMD8);
        return abort_to_error(r, EVT_ERROR);
      end
      ST_CMD8: begin
        if (e.response_byte1 == R1_IDLE) begin
          card_type = CARD_V2_SC;
          return issue_command(r, CMD_APP, '0, ST_A41_SEND);
        end
        card_type = CARD_V1;
        return abort_to_error(r, EVT_BAD_CARD);
      end
      ST_A41_SEND: begin
        if (e.response_byte1 == R1_IDLE)
          return issue_command(r, CMD_SEND_OP, (card_type == CARD_V1) ? '0 : ARG_HCS,
                               ST_A41_ANS);
        return abort_to_error(r, EVT_ERROR);
      end
      ST_A41_ANS: begin
        if (e.response_byte1 == R1_IDLE) begin
          tick_left = retry_reload;
          seq_state = ST_A41_WAIT;
          return 1'b0;
        end
        if (e.response_byte1 == R1_READY)
          return issue_command(r, CMD_READ_OCR, '0, ST_OCR);
        return abort_to_error(r, EVT_ERROR);
      end
      ST_OCR: begin
        if (e.response_byte1 == R1_READY) begin
          if (card_type == CARD_V2_SC && (e.response_byte2 & OCR_CCS) != '0)
            card_type = CARD_V2_HC;
          seq_state = ST_READY;
          return report_status(r, EVT_INIT, ST_READY);
        end
        return abort_to_error(r, EVT_ERROR);
      end
      ST_RD_CMD: begin
        // R1 may show up one byte late
        if (e.response_byte1 == R1_READY || e.response_byte2 == R1_READY)
          return issue_transfer(r, LEN_NONE, LEN_POLL, 1'b0, ST_RD_TOKEN);
        return abort_to_error(r, EVT_ERROR);
      end
      ST_RD_TOKEN: begin
        if (e.response_byte0 == TOKEN_START)
          return issue_transfer(r, LEN_NONE, LEN_DATA, 1'b1, ST_RD_DATA);
        seq_state = ST_RD_PAUSE;
        tick_left = poll_reload;
        return 1'b0;
      end
      ST_RD_DATA: begin
        seq_state = ST_READY;
        return report_block(r, e.data_crc_ok ? BLK_OK : BLK_CRC_ERR, last_block);
      end
      ST_WR_CMD: begin
        if (e.response_byte1 == R1_READY)
          return issue_transfer(r, LEN_DATA, LEN_R1, 1'b0, ST_WR_DATA);
        return abort_to_error(r, EVT_ERROR);
      end
      ST_WR_DATA: begin
        if ((e.response_byte0 & DRESP_MASK) == DRESP_OK)
          return issue_transfer(r, LEN_NONE, LEN_POLL, 1'b0, ST_WR_BUSY);
        return abort_to_error(r, EVT_ERROR);
      end
      ST_WR_BUSY: begin
        if (e.response_byte0 == BUSY_LOW)
          return issue_transfer(r, LEN_NONE, LEN_POLL, 1'b0, ST_WR_BUSY);
        return issue_command(r, CMD_STATUS, '0, ST_WR_STATUS);
      end
      ST_WR_STATUS: begin
        if (e.response_byte1 == R1_READY) begin
          seq_state = ST_READY;
          return report_block(r, BLK_OK, last_block);
        end
        return abort_to_error(r, EVT_ERROR);
      end
      default: return 1'b0;
    endcase
  endfunction

  // Advance the predictor by one accepted event beat; return 1 if a result is due.
  function automatic bit card_seq_step(input evt_item_t e, output res_item_t r);
    logic [31:0] arg;
    r = '0;
    case (e.op)
      OP_START: begin
        if (job_open) return 1'b0;
        card_type = CARD_UNKNOWN;
        seq_state = ST_UNDEF;
        return issue_command(r, CMD_GO_IDLE, '0, ST_RESET);
      end
      OP_READ, OP_WRITE: begin
        if (job_open) return 1'b0;
        // Standard-capacity cards are byte addressed
        arg = (card_type == CARD_V2_SC) ? (e.request_block << 9) : e.request_block;
        last_block = e.request_block;
        if (seq_state != ST_READY)
          return report_block(r, BLK_NOT_READY, e.request_block);
        if (e.op == OP_WRITE)
          return issue_command(r, CMD_WRITE, arg, ST_WR_CMD);
        return issue_command(r, CMD_READ, arg, ST_RD_CMD);
      end
      OP_DONE: begin
        if (!job_open) return 1'b0;
        job_open = 1'b0;
        if (!e.job_ok) begin
          seq_state = ST_ERROR;
          return 1'b0;
        end
        seq_state = seq_return;
        return answer_job(e, r);
      end
      OP_TICK: begin
        if (job_open) return 1'b0;
        if (seq_state != ST_A41_WAIT && seq_state != ST_RD_PAUSE) return 1'b0;
        if (tick_left == '0) return 1'b0;
        tick_left = tick_left - 16'd1;
        if (tick_left != '0) return 1'b0;
        if (seq_state == ST_A41_WAIT)
          return issue_command(r, CMD_APP, '0, ST_A41_SEND);
        return issue_transfer(r, LEN_NONE, LEN_POLL, 1'b0, ST_RD_TOKEN);
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one event beat: maybe idle a few cycles, then hold until accepted.
  // Leave valid high on return; the next call or settle drops it.
  task automatic send_event(input evt_item_t it);
    res_item_t r;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.data  <= it;
    do @(posedge clk); while (!evt_ch.ready);
    events_sent++;
    if (card_seq_step(it, r)) due_outputs.push_back(r);
  endtask

  // Drop valid, drain every due result, then give the pipeline a few cycles.
  task automatic settle;
    @(negedge clk);
    evt_ch.valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one configuration register; call only after settle.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
    if (idx == REG_INIT_RETRY) retry_reload = val;
    else if (idx == REG_TOKEN_POLL) poll_reload = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic evt_item_t make_event(input logic [2:0] op, input logic [31:0] blk,
                                           input logic ok, input logic [7:0] b0,
                                           input logic [7:0] b1, input logic [7:0] b2,
                                           input logic crc_ok);
    evt_item_t e;
    e.op             = op;
    e.request_block  = blk;
    e.job_ok         = ok;
    e.response_byte0 = b0;
    e.response_byte1 = b1;
    e.response_byte2 = b2;
    e.data_crc_ok    = crc_ok;
    return e;
  endfunction

  // Host-side request with quiet response fields.
  task automatic request(input logic [2:0] op, input logic [31:0] blk);
    send_event(make_event(op, blk, 1'b1, '0, '0, '0, 1'b1));
  endtask

  // Finish the open SPI job cleanly with the given received bytes.
  task automatic card_says(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    send_event(make_event(OP_DONE, '0, 1'b1, b0, b1, b2, 1'b1));
  endtask

  // Pick the next event the way a host and a card would produce it, with some
  // wrong answers, failed jobs and plain noise mixed in.
  function automatic evt_item_t pick_event();
    evt_item_t e;
    bit        good;
    e.op             = OP_TICK;
    e.request_block  = $urandom;
    e.job_ok         = ($urandom_range(99) >= 3);
    e.response_byte0 = 8'($urandom_range(255));
    e.response_byte1 = 8'($urandom_range(255));
    e.response_byte2 = 8'($urandom_range(255));
    e.data_crc_ok    = 1'($urandom_range(1));
    good             = ($urandom_range(99) < 85);
    if ($urandom_range(99) < 7) begin
      e.op = 3'($urandom_range(7));
      return e;
    end
    if (job_open) begin
      e.op = OP_DONE;
      if (good) begin
        case (seq_return)
          ST_RESET, ST_RESET2, ST_CMD8, ST_A41_SEND: e.response_byte1 = R1_IDLE;
          ST_A41_ANS:   e.response_byte1 = $urandom_range(1) ? R1_IDLE : R1_READY;
          ST_OCR, ST_WR_CMD, ST_WR_STATUS: e.response_byte1 = R1_READY;
          ST_RD_CMD: begin
            if ($urandom_range(1)) e.response_byte1 = R1_READY;
            else e.response_byte2 = R1_READY;
          end
          ST_RD_TOKEN:  if ($urandom_range(99) < 60) e.response_byte0 = TOKEN_START;
          ST_WR_DATA:   e.response_byte0[4:0] = DRESP_OK[4:0];
          ST_WR_BUSY:   if ($urandom_range(1)) e.response_byte0 = BUSY_LOW;
          default: ;
        endcase
      end
      return e;
    end
    case (seq_state)
      ST_A41_WAIT, ST_RD_PAUSE: e.op = ($urandom_range(99) < 97) ? OP_TICK : OP_START;
      ST_READY: begin
        case ($urandom_range(19))
          0:       e.op = OP_TICK;
          1:       e.op = OP_START;
          2, 3, 4, 5, 6, 7, 8, 9, 10: e.op = OP_READ;
          default: e.op = OP_WRITE;
        endcase
      end
      default: begin
        case ($urandom_range(9))
          0:       e.op = OP_READ;
          1:       e.op = OP_WRITE;
          2:       e.op = OP_TICK;
          default: e.op = OP_START;
        endcase
      end
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, comparison and the hang watchdog.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(negedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin : check_outputs
    res_item_t got;
    res_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (got.kind == KIND_JOB) jobs_seen++;
      else if (got.kind == KIND_BLOCK) blocks_seen++;
      else status_seen++;
      if (due_outputs.size() == 0) begin
        report_mismatch("result with nothing due, kind", 32'(got.kind), '0);
      end else begin
        want = due_outputs.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.command_byte !== want.command_byte)
          report_mismatch("command_byte", 32'(got.command_byte), 32'(want.command_byte));
        if (got.command_arg !== want.command_arg)
          report_mismatch("command_arg", got.command_arg, want.command_arg);
        if (got.command_crc !== want.command_crc)
          report_mismatch("command_crc", 32'(got.command_crc), 32'(want.command_crc));
        if (got.tx_length !== want.tx_length)
          report_mismatch("tx_length", 32'(got.tx_length), 32'(want.tx_length));
        if (got.rx_length !== want.rx_length)
          report_mismatch("rx_length", 32'(got.rx_length), 32'(want.rx_length));
        if (got.rx_to_data !== want.rx_to_data)
          report_mismatch("rx_to_data", 32'(got.rx_to_data), 32'(want.rx_to_data));
        if (got.block_result !== want.block_result)
          report_mismatch("block_result", 32'(got.block_result), 32'(want.block_result));
        if (got.done_block !== want.done_block)
          report_mismatch("done_block", got.done_block, want.done_block);
        if (got.event_code !== want.event_code)
          report_mismatch("event_code", 32'(got.event_code), 32'(want.event_code));
        if (got.event_state !== want.event_state)
          report_mismatch("event_state", 32'(got.event_state), 32'(want.event_state));
        if (got.card_kind !== want.card_kind)
          report_mismatch("card_kind", 32'(got.card_kind), 32'(want.card_kind));
      end
    end
  end

  // Count cycles without any beat on any channel; a stuck block ends the run.
  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == HANG_LIMIT) begin
        $display("[%0t] no beat for %0d cycles, %0d results still due", $realtime,
                 HANG_LIMIT, due_outputs.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Requests before any init, a stray job completion, a stray tick, unknown ops.
  task automatic test_before_init;
    request(OP_READ, '0);
    request(OP_WRITE, '1);
    card_says(8'hFF, 8'hFF, 8'hFF);
    request(OP_TICK, '0);
    request(OP_SPARE_LO, '1);
    request(OP_SPARE_HI, '1);
  endtask

  // Bring up a high-capacity card; CMD0 needs its one retry. Requests that
  // arrive while a job is open must be dropped.
  task automatic test_bring_up;
    request(OP_START, '0);
    request(OP_READ, 32'h0000_0001);
    request(OP_START, '0);
    card_says('0, R1_READY, '0);
    card_says('0, R1_IDLE, '0);
    card_says('0, R1_IDLE, '0);
    card_says('0, R1_IDLE, '0);
    card_says('0, R1_READY, '0);
    card_says('0, R1_READY, OCR_CCS | 8'h80);
  endtask

  // One read with a late R1, a token miss at the reset poll interval and a CRC
  // error; one write through busy and status; then a failed job.
  task automatic test_transfers;
    request(OP_READ, '1);
    request(OP_TICK, '0);
    card_says(8'hFF, 8'hFF, R1_READY);
    card_says(8'hFF, 8'hFF, 8'hFF);
    repeat (10) request(OP_TICK, '0);
    card_says(TOKEN_START, '0, '0);
    send_event(make_event(OP_DONE, '0, 1'b1, '0, '0, '0, 1'b0));
    request(OP_WRITE, '0);
    card_says('0, R1_READY, '0);
    card_says(8'hE5, '0, '0);
    card_says(BUSY_LOW, '0, '0);
    card_says(8'hFF, '0, '0);
    card_says('0, R1_READY, '0);
    // Transfer error on the SPI side: error state, nothing reported
    request(OP_WRITE, 32'h8000_0000);
    send_event(make_event(OP_DONE, '0, 1'b0, '0, R1_READY, '0, 1'b1));
    request(OP_READ, 32'h0000_0002);
  endtask

  // Register extremes: a zero retry wait never expires, a one-tick retry, a
  // 65535-tick token wait left by a new start; a v1 card; CMD0 failing twice.
  task automatic test_wait_registers;
    settle();
    write_reg(REG_SPARE_LO, 16'h0001);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    write_reg(REG_INIT_RETRY, 16'h0000);
    write_reg(REG_TOKEN_POLL, 16'hFFFF);
    request(OP_START, '0);
    repeat (3) card_says('0, R1_IDLE, '0);
    card_says('0, R1_IDLE, '0);
    repeat (3) request(OP_TICK, '0);
    request(OP_START, '0);
    card_says('0, R1_IDLE, '0);
    card_says('0, 8'h05, '0);
    settle();
    write_reg(REG_INIT_RETRY, 16'h0001);
    // Standard-capacity card: ACMD41 answers idle once, then ready
    request(OP_START, '0);
    repeat (4) card_says('0, R1_IDLE, '0);
    request(OP_TICK, '0);
    card_says('0, R1_IDLE, '0);
    card_says('0, R1_READY, '0);
    card_says('0, R1_READY, '0);
    card_says('0, R1_READY, 8'hBF);
    request(OP_READ, 32'h0000_0003);
    card_says('0, R1_READY, '0);
    card_says('0, '0, '0);
    repeat (3) request(OP_TICK, '0);
    request(OP_START, '0);
    card_says('0, 8'h7E, '0);
    card_says('0, 8'h81, '0);
  endtask

  // Card-like random traffic; no_gaps holds both sides at full rate.
  task automatic test_random_traffic(input int unsigned count, input bit no_gaps);
    steady = no_gaps;
    repeat (count) send_event(pick_event());
    steady = 1'b0;
  endtask

  initial begin
    // Predictor starts from the reset state of the block
    retry_reload = 16'd100;
    poll_reload  = 16'd10;
    seq_state    = ST_UNDEF;
    seq_return   = ST_UNDEF;
    job_open     = 1'b0;
    tick_left    = '0;
    card_type    = CARD_UNKNOWN;
    last_block   = '0;
    steady       = 1'b0;
    mismatches   = 0;
    events_sent  = 0;
    jobs_seen    = 0;
    blocks_seen  = 0;
    status_seen  = 0;
    reg_writes   = 0;
    quiet_cycles = 0;

    rst          = 1'b1;
    evt_ch.valid = 1'b0;
    evt_ch.data  = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.value = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_before_init();
    test_bring_up();
    test_transfers();
    test_wait_registers();

    settle();
    write_reg(REG_INIT_RETRY, 16'd2);
    write_reg(REG_TOKEN_POLL, 16'd1);
    test_random_traffic(400, 1'b0);

    settle();
    write_reg(REG_INIT_RETRY, 16'd1);
    write_reg(REG_TOKEN_POLL, 16'd3);
    test_random_traffic(400, 1'b1);

    settle();
    write_reg(REG_INIT_RETRY, 16'($urandom_range(1, 6)));
    write_reg(REG_TOKEN_POLL, 16'($urandom_range(1, 6)));
    test_random_traffic(350, 1'b0);

    // Back at the reset intervals for the last stretch
    settle();
    write_reg(REG_INIT_RETRY, 16'd100);
    write_reg(REG_TOKEN_POLL, 16'd10);
    test_random_traffic(400, 1'b0);

    settle();
    $display("Run covered %0d event beats and %0d register writes", events_sent, reg_writes);
    $display("Results checked: %0d SPI jobs, %0d block reports, %0d status events",
             jobs_seen, blocks_seen, status_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
